### rtl/core/hrs_pkg.sv
// Shared types and constants for the histogram rank statistics core.
// No dependencies; imported by every module under rtl/core.
package hrs_pkg;

    localparam int VALUE_W     = 14;
    localparam int VALUE_RANGE = 2 ** VALUE_W;
    localparam int CNT_W       = 17;
    localparam int NUM_W       = 24;
    localparam int QUOT_W      = 7;

    localparam logic [CNT_W-1:0]   MAX_SAMPLES = CNT_W'(65536);
    localparam logic [NUM_W-1:0]   PCT_SCALE   = NUM_W'(100);
    localparam logic [VALUE_W-1:0] VALUE_MAX   = VALUE_W'(VALUE_RANGE - 1);

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_ADD   = 3'd1;
    localparam logic [2:0] ACT_AMP   = 3'd2;
    localparam logic [2:0] ACT_MED   = 3'd3;
    localparam logic [2:0] ACT_PCT   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_W-1:0] result;
        logic [1:0]         status;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [CNT_W-1:0] den;
    } t_div_req;

endpackage

### rtl/core/hrs_hist_mem.sv
// Histogram store: one write port, one read port, registered read data.
// Depends on hrs_pkg.
module hrs_hist_mem
    import hrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [VALUE_W-1:0] i_waddr,
    input  logic [CNT_W-1:0]   i_wdata,
    input  logic [VALUE_W-1:0] i_raddr,
    output logic [CNT_W-1:0]   o_rdata
);

    logic [CNT_W-1:0] r_mem [VALUE_RANGE];
    logic [CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/hrs_divider.sv
// Restoring divider for the percentile: one quotient bit per cycle.
// Depends on hrs_pkg; the quotient fits QUOT_W bits since num <= 100 * den.
module hrs_divider
    import hrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [$clog2(QUOT_W)-1:0] r_step, n_step;
    logic [NUM_W-1:0]          r_rem, n_rem;
    logic [CNT_W-1:0]          r_den, n_den;
    logic [QUOT_W-1:0]         r_quot, n_quot;
    logic [NUM_W-1:0]          shifted;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_step  = r_step;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quot  = r_quot;
        shifted = NUM_W'(r_den) << r_step;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = $bits(r_step)'(QUOT_W - 1);
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_quot = '0;
        end else if (r_busy) begin
            if (r_rem >= shifted) begin
                n_rem  = r_rem - shifted;
                n_quot = r_quot | (QUOT_W'(1) << r_step);
            end
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_quot <= QUOT_W'(100))
        else $error("percentile quotient above 100");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> i_req.den != '0)
        else $error("division started with zero divisor");

endmodule

### rtl/core/histogram_rank_statistics_core.sv
// Top level of the histogram rank statistics core: control sequencer and
// output register. Depends on hrs_pkg, hrs_hist_mem and hrs_divider.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-----------
//  in      | input     | i_in_valid / o_in_stall   | t_in_word
//  out     | output    | o_out_valid / i_out_stall | t_out_word
//
// Per action, after acceptance and before the S_DONE state that loads the
// output register: add reads the histogram entry, then writes count + 1;
// amplitude and unused codes go straight to S_DONE; median walks the
// histogram one entry per cycle over the single read port up to the upper
// middle value; percentile walks the entries below the threshold, then runs
// the divider (seven quotient bits, then done); clear zeroes all 16384
// entries, one per cycle through the write port. After reset the same
// clearing pass runs while o_in_stall is high. A result held by i_out_stall
// blocks the next completion only; the next word is still accepted.
module histogram_rank_statistics_core
    import hrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_WR,
        S_WALK,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [VALUE_W-1:0] r_min, n_min;
    logic [VALUE_W-1:0] r_max, n_max;
    logic [VALUE_W-1:0] r_addr, n_addr;
    logic [VALUE_W-1:0] r_dat_addr, n_dat_addr;
    logic [CNT_W-1:0]   r_cum, n_cum;
    logic [CNT_W-1:0]   r_k1, n_k1;
    logic [CNT_W-1:0]   r_k2, n_k2;
    logic [VALUE_W-1:0] r_v1, n_v1;
    logic               r_found1, n_found1;
    logic               r_is_med, n_is_med;
    logic [VALUE_W-1:0] r_thr, n_thr;
    logic [VALUE_W-1:0] r_res, n_res;
    logic [1:0]         r_stat, n_stat;
    logic               r_pend, n_pend;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_data, n_out_data;

    logic               in_acc;
    logic               mem_we;
    logic [VALUE_W-1:0] mem_waddr;
    logic [CNT_W-1:0]   mem_wdata;
    logic [VALUE_W-1:0] mem_raddr;
    logic [CNT_W-1:0]   mem_rdata;
    logic [CNT_W-1:0]   cum_sum;
    logic [VALUE_W-1:0] v1_final;
    logic [VALUE_W:0]   mid_sum;
    t_div_req           div_req;
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;

    hrs_hist_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hrs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign cum_sum    = r_cum + mem_rdata;
    assign v1_final   = r_found1 ? r_v1 : r_dat_addr;
    assign mid_sum    = (VALUE_W + 1)'(v1_final) + (VALUE_W + 1)'(r_dat_addr);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_addr      = r_addr;
        n_dat_addr  = r_dat_addr;
        n_cum       = r_cum;
        n_k1        = r_k1;
        n_k2        = r_k2;
        n_v1        = r_v1;
        n_found1    = r_found1;
        n_is_med    = r_is_med;
        n_thr       = r_thr;
        n_res       = r_res;
        n_stat      = r_stat;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;
        mem_raddr   = r_addr;
        div_req     = '0;

        unique case (r_state)
            S_CLEAR: begin
                // Zero one entry per cycle; restore the scalars at the end.
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == VALUE_MAX) begin
                    n_count = '0;
                    n_min   = VALUE_MAX;
                    n_max   = '0;
                    n_res   = '0;
                    n_stat  = ST_OK;
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                // Adds read the target entry, walks start at entry zero.
                mem_raddr = (i_in_data.action == ACT_ADD) ? i_in_data.value : '0;
                if (in_acc) begin
                    n_res   = '0;
                    n_stat  = ST_OK;
                    n_state = S_DONE;
                    unique case (i_in_data.action)
                        ACT_CLEAR: begin
                            n_addr  = '0;
                            n_pend  = 1'b1;
                            n_state = S_CLEAR;
                        end
                        ACT_ADD: begin
                            if (r_count >= MAX_SAMPLES) begin
                                n_stat = ST_FULL;
                            end else begin
                                n_addr  = i_in_data.value;
                                n_state = S_ADD_WR;
                            end
                        end
                        ACT_AMP: begin
                            if (r_count == '0) begin
                                n_stat = ST_EMPTY;
                            end else begin
                                n_res = r_max - r_min;
                            end
                        end
                        ACT_MED, ACT_PCT: begin
                            n_addr     = VALUE_W'(1);
                            n_dat_addr = '0;
                            n_cum      = '0;
                            n_found1   = 1'b0;
                            n_is_med   = (i_in_data.action == ACT_MED);
                            n_thr      = i_in_data.value;
                            if (r_count[0]) begin
                                n_k1 = (r_count - 1'b1) >> 1;
                                n_k2 = (r_count - 1'b1) >> 1;
                            end else begin
                                n_k1 = (r_count >> 1) - 1'b1;
                                n_k2 = r_count >> 1;
                            end
                            if (r_count == '0) begin
                                n_stat = ST_EMPTY;
                            end else if (i_in_data.action == ACT_PCT
                                         && i_in_data.value == '0) begin
                                // Nothing lies below zero: divide zero.
                                div_req.start = 1'b1;
                                div_req.num   = '0;
                                div_req.den   = r_count;
                                n_state       = S_DIV;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata + 1'b1;
                n_count   = r_count + 1'b1;
                if (r_addr < r_min) begin
                    n_min = r_addr;
                end
                if (r_addr > r_max) begin
                    n_max = r_addr;
                end
                n_state = S_DONE;
            end
            S_WALK: begin
                // Accumulate the entry that arrives; keep the next read going.
                n_cum      = cum_sum;
                n_addr     = r_addr + 1'b1;
                n_dat_addr = r_dat_addr + 1'b1;
                if (r_is_med) begin
                    if (!r_found1 && cum_sum > r_k1) begin
                        n_v1     = r_dat_addr;
                        n_found1 = 1'b1;
                    end
                    if (cum_sum > r_k2) begin
                        n_res   = mid_sum[VALUE_W:1];
                        n_state = S_DONE;
                    end
                end else if (r_dat_addr == r_thr - 1'b1) begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(cum_sum) * PCT_SCALE;
                    div_req.den   = r_count;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = VALUE_W'(div_quot);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid        = 1'b1;
                    n_out_data.result  = r_res;
                    n_out_data.status  = r_stat;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_min       <= VALUE_MAX;
            r_max       <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
        end
        r_dat_addr <= n_dat_addr;
        r_cum      <= n_cum;
        r_k1       <= n_k1;
        r_k2       <= n_k2;
        r_v1       <= n_v1;
        r_found1   <= n_found1;
        r_is_med   <= n_is_med;
        r_thr      <= n_thr;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_SAMPLES)
        else $error("sample count above store size");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 |-> r_min <= r_max)
        else $error("minimum above maximum with samples loaded");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("word accepted without leaving idle");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_count != '0)
        else $error("histogram walk on an empty store");

endmodule

### test/tb_histogram_rank_statistics_core.sv
// Testbench for histogram_rank_statistics_core: directed and random stimulus, in-order
// checking against a behavioral histogram predictor. Depends on hrs_pkg and the core RTL.
module tb_histogram_rank_statistics_core;
    import hrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 120000;  // covers the clearing pass plus a full walk
    localparam int DRAIN_CYCLES   = 40;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_data;

    histogram_rank_statistics_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Predictor state: a private copy of the histogram and running statistics.
    int unsigned      bin_count [VALUE_RANGE];
    int unsigned      total_samples;
    logic [VALUE_W-1:0] low_value;
    logic [VALUE_W-1:0] high_value;

    t_out_word expected_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_token;
    int hold_seen;
    int hold_left;
    int hold_cycles;
    int mismatches;
    int words_sent;
    int words_checked;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Value at sorted position k; walk the cumulative counts.
    function automatic logic [VALUE_W-1:0] value_at_rank(int unsigned k);
        int unsigned cum;
        cum = 0;
        for (int v = 0; v < VALUE_RANGE; v++) begin
            cum += bin_count[v];
            if (cum > k) return VALUE_W'(v);
        end
        return VALUE_MAX;
    endfunction

    // Advance the predictor by one word and return the result it must produce.
    function automatic t_out_word predict_stats(t_in_word w);
        t_out_word     r;
        longint unsigned below;
        int unsigned   half;
        int unsigned   lo_v;
        int unsigned   hi_v;
        r = '0;
        case (w.action)
            ACT_CLEAR: begin
                foreach (bin_count[i]) bin_count[i] = 0;
                total_samples = 0;
                low_value     = VALUE_MAX;
                high_value    = '0;
            end
            ACT_ADD: begin
                if (total_samples >= MAX_SAMPLES) begin
                    r.status = ST_FULL;
                end else begin
                    bin_count[w.value]++;
                    total_samples++;
                    if (w.value < low_value) low_value = w.value;
                    if (w.value > high_value) high_value = w.value;
                end
            end
            ACT_AMP: begin
                if (total_samples == 0) r.status = ST_EMPTY;
                else r.result = high_value - low_value;
            end
            ACT_MED: begin
                if (total_samples == 0) begin
                    r.status = ST_EMPTY;
                end else if (total_samples[0]) begin
                    r.result = value_at_rank((total_samples - 1) / 2);
                end else begin
                    half     = total_samples / 2;
                    lo_v     = value_at_rank(half - 1);
                    hi_v     = value_at_rank(half);
                    r.result = VALUE_W'((lo_v + hi_v) / 2);
                end
            end
            ACT_PCT: begin
                if (total_samples == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    below = 0;
                    for (int v = 0; v < w.value; v++) below += bin_count[v];
                    r.result = VALUE_W'((below * 100) / total_samples);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one word, hold it until accepted, then record its expected result.
    task automatic send_word(logic [2:0] action, logic [VALUE_W-1:0] value);
        t_in_word w;
        w.action = action;
        w.value  = value;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_stats(w));
        words_sent++;
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Extremes, every action, empty store, unused codes and clear.
    task automatic test_directed();
        send_word(ACT_AMP, '0);
        send_word(ACT_MED, '0);
        send_word(ACT_PCT, VALUE_MAX);
        send_word(ACT_ADD, '0);
        send_word(ACT_ADD, VALUE_MAX);
        send_word(ACT_AMP, '0);
        send_word(ACT_MED, '0);
        send_word(ACT_ADD, VALUE_W'(5));
        send_word(ACT_MED, '0);
        send_word(ACT_PCT, '0);
        send_word(ACT_PCT, VALUE_W'(1));
        send_word(ACT_PCT, VALUE_W'(6));
        send_word(ACT_PCT, VALUE_MAX);
        send_word(3'd5, VALUE_MAX);
        send_word(3'd6, '0);
        send_word(3'd7, VALUE_W'(16'h2AAA));
        send_word(ACT_CLEAR, VALUE_MAX);
        send_word(ACT_AMP, '0);
        send_word(ACT_MED, '0);
        send_word(ACT_PCT, VALUE_W'(3));
        drain_results();
    endtask

    // Hold the output long enough that the input backs up.
    task automatic test_backpressure();
        hold_cycles = 400;
        hold_token <= hold_token + 1;
        for (int i = 0; i < 40; i++) send_word(ACT_ADD, VALUE_W'($urandom_range(200)));
        send_word(ACT_MED, '0);
        drain_results();
    endtask

    // Mostly small samples keep the walks short; a few reach the full range.
    task automatic test_random(int count);
        int unsigned pick;
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(999);
            v = ($urandom_range(9) == 0) ? VALUE_W'($urandom) : VALUE_W'($urandom_range(255));
            if (pick < 3)        send_word(ACT_CLEAR, VALUE_W'($urandom));
            else if (pick < 600) send_word(ACT_ADD, v);
            else if (pick < 720) send_word(ACT_AMP, VALUE_W'($urandom));
            else if (pick < 840) send_word(ACT_MED, VALUE_W'($urandom));
            else if (pick < 950) send_word(ACT_PCT,
                ($urandom_range(99) == 0) ? VALUE_W'($urandom) : VALUE_W'($urandom_range(300)));
            else                 send_word(3'($urandom_range(7, 5)), VALUE_W'($urandom));
        end
        drain_results();
    endtask

    // Receiver: random stall, or a long hold when a test asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_seen   <= 0;
            hold_left   <= 0;
            i_out_stall <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= hold_cycles;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: %h", o_out_data);
                mismatches++;
            end else begin
                exp_word = expected_results.pop_front();
                words_checked++;
                if (o_out_data.result !== exp_word.result) begin
                    $error("result: expected %0d, got %0d", exp_word.result, o_out_data.result);
                    mismatches++;
                end
                if (o_out_data.status !== exp_word.status) begin
                    $error("status: expected %0d, got %0d", exp_word.status, o_out_data.status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL histogram_rank_statistics_core");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_token     = 0;
        hold_cycles    = 0;
        mismatches     = 0;
        words_sent     = 0;
        words_checked  = 0;
        quiet_cycles   = 0;
        foreach (bin_count[i]) bin_count[i] = 0;
        total_samples = 0;
        low_value     = VALUE_MAX;
        high_value    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        test_directed();
        test_backpressure();
        test_random(340);
        set_idling(77, 0);
        test_random(340);
        set_idling(0, 77);
        test_random(340);
        set_idling(12, 12);
        test_random(340);

        $display("Covered all actions, empty store, unused codes, clears and a long output hold;");
        $display("%0d words sent, %0d results checked under four idling mixes.",
                 words_sent, words_checked);
        if (mismatches == 0) begin
            $display("PASS histogram_rank_statistics_core");
        end else begin
            $display("FAIL histogram_rank_statistics_core");
        end
        $finish;
    end

endmodule
